/* rtl/hrlc_pkg.sv */
// Package with the state type, keyword tables and per-byte helpers of the request line checker.
package hrlc_pkg;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   localparam logic [2:0] TOKEN_METHOD  = 3'd1;
   localparam logic [2:0] TOKEN_PATH    = 3'd2;
   localparam logic [2:0] TOKEN_VERSION = 3'd3;
   localparam logic [2:0] TOKEN_MAX     = 3'd4;

   localparam logic [3:0] METHOD_LEN  = 4'd3;
   localparam logic [3:0] VERSION_LEN = 4'd8;
   localparam logic [3:0] HEAD_LEN    = 4'd7;
   localparam logic [3:0] POS_MAX     = 4'd15;

   // "GET" and the common "HTTP/1." prefix of both versions.
   localparam logic [7:0] METHOD_TEXT [3] = '{8'h47, 8'h45, 8'h54};
   localparam logic [7:0] VERSION_HEAD [7] =
      '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E};

   typedef struct packed {
      logic [2:0] token_count;
      logic [3:0] char_pos;
      logic       inside_token;
      logic       method_match;
      logic       version11_match;
      logic       version10_match;
      logic       line_bad;
      logic       string_ended;
   } state_type;

   typedef struct packed {
      logic       path_valid;
      logic [7:0] path_char;
      logic       verdict_valid;
      logic       accepted;
   } result_type;

   localparam state_type STATE_RESET = '{
      token_count:     3'd0,
      char_pos:        4'd0,
      inside_token:    1'b0,
      method_match:    1'b1,
      version11_match: 1'b1,
      version10_match: 1'b1,
      line_bad:        1'b0,
      string_ended:    1'b0
   };

   // Ends an open token; a method or version of the wrong length fails here.
   function automatic state_type close_token(state_type s);
      state_type r;
      r = s;
      if (s.inside_token) begin
         if (s.token_count == TOKEN_METHOD && s.char_pos != METHOD_LEN) begin
            r.method_match = 1'b0;
         end
         if (s.token_count == TOKEN_VERSION && s.char_pos != VERSION_LEN) begin
            r.version11_match = 1'b0;
            r.version10_match = 1'b0;
         end
         r.inside_token = 1'b0;
      end
      return r;
   endfunction

   // Compares one byte against the keyword expected at its position.
   function automatic state_type match_byte(state_type s, logic [7:0] c);
      state_type r;
      r = s;
      if (s.token_count == TOKEN_METHOD) begin
         if (s.char_pos >= METHOD_LEN) begin
            r.method_match = 1'b0;
         end else if (METHOD_TEXT[s.char_pos[1:0]] != c) begin
            r.method_match = 1'b0;
         end
      end else if (s.token_count == TOKEN_VERSION) begin
         if (s.char_pos >= VERSION_LEN) begin
            r.version11_match = 1'b0;
            r.version10_match = 1'b0;
         end else if (s.char_pos < HEAD_LEN) begin
            if (VERSION_HEAD[s.char_pos[2:0]] != c) begin
               r.version11_match = 1'b0;
               r.version10_match = 1'b0;
            end
         end else begin
            if (c != CHAR_ONE) begin
               r.version11_match = 1'b0;
            end
            if (c != CHAR_ZERO) begin
               r.version10_match = 1'b0;
            end
         end
      end
      return r;
   endfunction

endpackage

/* rtl/hrlc_step.sv */
// Combinational per-byte update of the line state and the result for that byte.
module hrlc_step (
   input  hrlc_pkg::state_type  state_cur,
   input  logic [7:0]           char_in,
   input  logic                 line_end,
   output hrlc_pkg::state_type  state_next,
   output hrlc_pkg::result_type result
);

   hrlc_pkg::state_type work;
   hrlc_pkg::state_type closed;

   always_comb begin
      work               = state_cur;
      result.path_valid  = 1'b0;
      result.path_char   = 8'd0;
      if (!state_cur.string_ended) begin
         if (char_in == hrlc_pkg::CHAR_NUL || char_in == hrlc_pkg::CHAR_SPACE) begin
            work = hrlc_pkg::close_token(state_cur);
            if (char_in == hrlc_pkg::CHAR_NUL) begin
               work.string_ended = 1'b1;
            end
         end else begin
            if (!work.inside_token) begin
               if (work.token_count < hrlc_pkg::TOKEN_MAX) begin
                  work.token_count = work.token_count + 3'd1;
               end
               if (work.token_count > hrlc_pkg::TOKEN_VERSION) begin
                  work.line_bad = 1'b1;
               end
               work.inside_token = 1'b1;
               work.char_pos     = 4'd0;
            end
            work = hrlc_pkg::match_byte(work, char_in);
            if (work.token_count == hrlc_pkg::TOKEN_PATH) begin
               result.path_valid = 1'b1;
               result.path_char  = char_in;
            end
            if (work.char_pos < hrlc_pkg::POS_MAX) begin
               work.char_pos = work.char_pos + 4'd1;
            end
         end
      end

      closed               = hrlc_pkg::close_token(work);
      result.verdict_valid = line_end;
      result.accepted      = line_end && !closed.line_bad &&
                             closed.token_count == hrlc_pkg::TOKEN_VERSION &&
                             closed.method_match &&
                             (closed.version11_match || closed.version10_match);
      state_next           = line_end ? hrlc_pkg::STATE_RESET : work;
   end

endmodule

/* rtl/http_request_line_checker_top.sv */
// Top level of the request line checker: input register, per-byte step, result register.
// A byte in the input register goes through the step into the result register.
// Throughput: one byte per cycle unless stalled; each state update is one logic step.
// The input register keeps taking bytes while a result waits, until both stages are full.
// Reset (synchronous, active high) empties both stages and returns the line state to idle.
module http_request_line_checker_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   input  logic       req_line_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_path_valid,
   output logic [7:0] rsp_path_char,
   output logic       rsp_verdict_valid,
   output logic       rsp_accepted
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_char_ff;
   logic                 in_last_ff;
   logic                 out_valid_ff, out_valid_in;
   hrlc_pkg::result_type out_result_ff;
   hrlc_pkg::state_type  state_ff, state_in;
   hrlc_pkg::state_type  step_state;
   hrlc_pkg::result_type step_result;
   logic                 out_free;
   logic                 advance;
   logic                 req_take;

   hrlc_step u_step (
      .state_cur  (state_ff),
      .char_in    (in_char_ff),
      .line_end   (in_last_ff),
      .state_next (step_state),
      .result     (step_result)
   );

   always_comb begin
      out_free     = !out_valid_ff || !rsp_stall;
      advance      = in_valid_ff && out_free;
      req_stall    = in_valid_ff && !out_free;
      req_take     = req_valid && !req_stall;
      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && rsp_stall);
      state_in     = advance ? step_state : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= hrlc_pkg::STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_char_in;
         in_last_ff <= req_line_end;
      end
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_path_valid    = out_result_ff.path_valid;
   assign rsp_path_char     = out_result_ff.path_char;
   assign rsp_verdict_valid = out_result_ff.verdict_valid;
   assign rsp_accepted      = out_result_ff.accepted;

endmodule

/* rtl/hrlc_checker.sv */
// Port-level assertions for the request line checker and their binding to the top level.
module hrlc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_path_valid,
   input logic [7:0] rsp_path_char,
   input logic       rsp_verdict_valid,
   input logic       rsp_accepted
);

   // A verdict of acceptance only ever comes with the final byte of a line.
   a_accept_needs_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_accepted || rsp_verdict_valid))
      else $error("accepted set without verdict_valid");

   // A result that is not a path byte carries a zero byte.
   a_path_char_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_path_valid) |-> (rsp_path_char == 8'd0))
      else $error("path_char nonzero without path_valid");

   // With the result register empty the input side is never held off.
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result register");

   // Both stages are empty right after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!rsp_valid && !req_stall))
      else $error("block not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_path_valid) &&
         $stable(rsp_path_char) && $stable(rsp_verdict_valid) && $stable(rsp_accepted)))
      else $error("stalled result changed");

endmodule

bind http_request_line_checker_top hrlc_checker u_hrlc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_path_valid    (rsp_path_valid),
   .rsp_path_char     (rsp_path_char),
   .rsp_verdict_valid (rsp_verdict_valid),
   .rsp_accepted      (rsp_accepted)
);

/* verif/tb_top.sv */
// Self-checking testbench for the request line checker: directed rows, then random lines.
`timescale 1ns / 1ps

module tb_top;

   typedef struct packed {
      logic [7:0]           ch;
      logic                 last;
      logic                 typed;
      hrlc_pkg::result_type want;
   } stim_row_type;

   localparam hrlc_pkg::result_type NO_CHECK = '0;
   localparam hrlc_pkg::result_type REJECTED =
      '{path_valid: 1'b0, path_char: 8'h00, verdict_valid: 1'b1, accepted: 1'b0};
   localparam hrlc_pkg::result_type ACCEPTED =
      '{path_valid: 1'b0, path_char: 8'h00, verdict_valid: 1'b1, accepted: 1'b1};
   localparam hrlc_pkg::result_type PATH_7F_REJECTED =
      '{path_valid: 1'b1, path_char: 8'h7F, verdict_valid: 1'b1, accepted: 1'b0};

   localparam int NUM_DIRECTED = 29;
   localparam int RANDOM_ITEMS = 1100;

   localparam stim_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      // One-byte lines right after reset: top byte, zero byte, lone space.
      '{8'hFF, 1'b1, 1'b1, REJECTED},
      '{8'h00, 1'b1, 1'b1, REJECTED},
      '{8'h20, 1'b1, 1'b1, REJECTED},
      // A well-formed line.
      '{"G", 1'b0, 1'b0, NO_CHECK},
      '{"E", 1'b0, 1'b0, NO_CHECK},
      '{"T", 1'b0, 1'b0, NO_CHECK},
      '{" ", 1'b0, 1'b0, NO_CHECK},
      '{"/", 1'b0, 1'b0, NO_CHECK},
      '{" ", 1'b0, 1'b0, NO_CHECK},
      '{"H", 1'b0, 1'b0, NO_CHECK},
      '{"T", 1'b0, 1'b0, NO_CHECK},
      '{"T", 1'b0, 1'b0, NO_CHECK},
      '{"P", 1'b0, 1'b0, NO_CHECK},
      '{"/", 1'b0, 1'b0, NO_CHECK},
      '{"1", 1'b0, 1'b0, NO_CHECK},
      '{".", 1'b0, 1'b0, NO_CHECK},
      '{"1", 1'b1, 1'b1, ACCEPTED},
      // Too few tokens, and the final byte is a path byte as well.
      '{"x", 1'b0, 1'b0, NO_CHECK},
      '{" ", 1'b0, 1'b0, NO_CHECK},
      '{8'h7F, 1'b1, 1'b1, PATH_7F_REJECTED},
      // Bad method, a fourth token, then a zero byte and an ignored byte.
      '{"a", 1'b0, 1'b0, NO_CHECK},
      '{" ", 1'b0, 1'b0, NO_CHECK},
      '{8'h80, 1'b0, 1'b0, NO_CHECK},
      '{" ", 1'b0, 1'b0, NO_CHECK},
      '{"c", 1'b0, 1'b0, NO_CHECK},
      '{" ", 1'b0, 1'b0, NO_CHECK},
      '{"d", 1'b0, 1'b0, NO_CHECK},
      '{8'h00, 1'b0, 1'b0, NO_CHECK},
      '{"e", 1'b1, 1'b1, REJECTED}
   };

   localparam logic [7:0] GET_WORD [3] = '{"G", "E", "T"};
   localparam logic [7:0] VERSION_PREFIX [7] = '{"H", "T", "T", "P", "/", "1", "."};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_in = 8'h00;
   logic       req_line_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_path_valid;
   logic [7:0] rsp_path_char;
   logic       rsp_verdict_valid;
   logic       rsp_accepted;

   // Line state of the predictor.
   logic [2:0] tokens_seen;
   logic [3:0] token_pos;
   logic       token_open;
   logic       get_ok;
   logic       http11_ok;
   logic       http10_ok;
   logic       extra_token;
   logic       nul_seen;

   hrlc_pkg::result_type pending_results [$];
   logic [7:0]           line_bytes [$];
   hrlc_pkg::result_type head_result;
   int         mismatch_count = 0;
   int         burst_left = 0;
   int         stall_mode = 0;
   int         stall_mode_left = 0;
   int         stall_phase = 0;

   http_request_line_checker_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_in       (req_char_in),
      .req_line_end      (req_line_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_path_valid    (rsp_path_valid),
      .rsp_path_char     (rsp_path_char),
      .rsp_verdict_valid (rsp_verdict_valid),
      .rsp_accepted      (rsp_accepted)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_line();
      tokens_seen = 3'd0;
      token_pos   = 4'd0;
      token_open  = 1'b0;
      get_ok      = 1'b1;
      http11_ok   = 1'b1;
      http10_ok   = 1'b1;
      extra_token = 1'b0;
      nul_seen    = 1'b0;
   endfunction

   // A method or version whose length differs from its keyword fails when it closes.
   function automatic void end_token();
      if (token_open) begin
         if (tokens_seen == hrlc_pkg::TOKEN_METHOD && token_pos != hrlc_pkg::METHOD_LEN) begin
            get_ok = 1'b0;
         end
         if (tokens_seen == hrlc_pkg::TOKEN_VERSION &&
             token_pos != hrlc_pkg::VERSION_LEN) begin
            http11_ok = 1'b0;
            http10_ok = 1'b0;
         end
         token_open = 1'b0;
      end
   endfunction

   function automatic void check_keyword_byte(input logic [7:0] c);
      if (tokens_seen == hrlc_pkg::TOKEN_METHOD) begin
         if (token_pos >= hrlc_pkg::METHOD_LEN) begin
            get_ok = 1'b0;
         end else if (GET_WORD[token_pos[1:0]] != c) begin
            get_ok = 1'b0;
         end
      end else if (tokens_seen == hrlc_pkg::TOKEN_VERSION) begin
         if (token_pos >= hrlc_pkg::VERSION_LEN) begin
            http11_ok = 1'b0;
            http10_ok = 1'b0;
         end else if (token_pos < hrlc_pkg::HEAD_LEN) begin
            if (VERSION_PREFIX[token_pos[2:0]] != c) begin
               http11_ok = 1'b0;
               http10_ok = 1'b0;
            end
         end else begin
            if (c != "1") begin
               http11_ok = 1'b0;
            end
            if (c != "0") begin
               http10_ok = 1'b0;
            end
         end
      end
   endfunction

   function automatic hrlc_pkg::result_type predict_line_byte(input logic [7:0] c,
                                                              input logic last);
      hrlc_pkg::result_type r;
      r = '0;
      if (!nul_seen) begin
         if (c == hrlc_pkg::CHAR_NUL) begin
            end_token();
            nul_seen = 1'b1;
         end else if (c == hrlc_pkg::CHAR_SPACE) begin
            end_token();
         end else begin
            if (!token_open) begin
               if (tokens_seen < hrlc_pkg::TOKEN_MAX) begin
                  tokens_seen = tokens_seen + 3'd1;
               end
               if (tokens_seen > hrlc_pkg::TOKEN_VERSION) begin
                  extra_token = 1'b1;
               end
               token_open = 1'b1;
               token_pos  = 4'd0;
            end
            check_keyword_byte(c);
            if (tokens_seen == hrlc_pkg::TOKEN_PATH) begin
               r.path_valid = 1'b1;
               r.path_char  = c;
            end
            if (token_pos < hrlc_pkg::POS_MAX) begin
               token_pos = token_pos + 4'd1;
            end
         end
      end
      if (last) begin
         end_token();
         r.verdict_valid = 1'b1;
         r.accepted = !extra_token && tokens_seen == hrlc_pkg::TOKEN_VERSION && get_ok &&
                      (http11_ok || http10_ok);
         clear_line();
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("tb_top: mismatch in %s at %0t: got %h, expected %h", what, $realtime, got,
               want);
      mismatch_count++;
   endtask

   // Offers one item; the sender may idle between bursts of random length.
   task automatic send_byte(input logic [7:0] c, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 12);
      end
      req_valid    <= 1'b1;
      req_char_in  <= c;
      req_line_end <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] token_byte();
      logic [7:0] c;
      do begin
         c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                         : 8'($urandom_range(33, 126));
      end while (c == hrlc_pkg::CHAR_SPACE);
      return c;
   endfunction

   task automatic push_token(input int len);
      repeat (len) line_bytes.push_back(token_byte());
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         line_bytes.push_back(s[i]);
      end
   endtask

   task automatic push_spaces(input int n);
      repeat (n) line_bytes.push_back(hrlc_pkg::CHAR_SPACE);
   endtask

   // Mostly request-shaped lines with random content, often broken, some pure noise.
   task automatic build_line();
      int n;
      int idx;
      line_bytes.delete();
      if ($urandom_range(0, 99) < 75) begin
         push_spaces($urandom_range(0, 2));
         if ($urandom_range(0, 4) != 0) begin
            push_text("GET");
         end else begin
            case ($urandom_range(0, 3))
               0: push_text("GE");
               1: push_text("GETT");
               2: push_text("get");
               default: push_token($urandom_range(1, 5));
            endcase
         end
         push_spaces($urandom_range(1, 3));
         push_token(($urandom_range(0, 9) == 0) ? $urandom_range(14, 20)
                                                : $urandom_range(1, 6));
         push_spaces($urandom_range(1, 3));
         case ($urandom_range(0, 11))
            0: push_text("HTTP/1.2");
            1: push_text("HTTP/1.");
            2: push_text("HTTP/1.10");
            3: push_token($urandom_range(1, 18));
            4, 5, 6, 7: push_text("HTTP/1.0");
            default: push_text("HTTP/1.1");
         endcase
         push_spaces($urandom_range(0, 2));
         if ($urandom_range(0, 9) == 0) begin
            push_spaces(1);
            push_token($urandom_range(1, 4));
         end
         if ($urandom_range(0, 9) == 0) begin
            idx = $urandom_range(0, line_bytes.size() - 1);
            line_bytes[idx] = 8'($urandom_range(0, 255));
         end
         if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, line_bytes.size());
            while (line_bytes.size() > n) void'(line_bytes.pop_back());
         end
         if ($urandom_range(0, 14) == 0) begin
            line_bytes.push_back(hrlc_pkg::CHAR_NUL);
            repeat ($urandom_range(0, 3)) line_bytes.push_back(8'($urandom_range(0, 255)));
         end
      end else begin
         repeat ($urandom_range(1, 24)) begin
            case ($urandom_range(0, 19))
               0: line_bytes.push_back(hrlc_pkg::CHAR_NUL);
               1, 2, 3, 4, 5, 6: line_bytes.push_back(hrlc_pkg::CHAR_SPACE);
               default: line_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
         end
      end
   endtask

   // The receiver switches among no stall, light, heavy and periodic stalling.
   always @(posedge clock) begin
      if (stall_mode_left == 0) begin
         stall_mode      = $urandom_range(0, 3);
         stall_mode_left = $urandom_range(20, 200);
      end
      stall_mode_left--;
      stall_phase++;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= stall_phase[2];
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected item (path_char)", rsp_path_char, 8'h00);
         end else begin
            head_result = pending_results.pop_front();
            if (rsp_path_valid !== head_result.path_valid) begin
               report_mismatch("path_valid", 8'(rsp_path_valid),
                               8'(head_result.path_valid));
            end
            if (rsp_path_char !== head_result.path_char) begin
               report_mismatch("path_char", rsp_path_char, head_result.path_char);
            end
            if (rsp_verdict_valid !== head_result.verdict_valid) begin
               report_mismatch("verdict_valid", 8'(rsp_verdict_valid),
                               8'(head_result.verdict_valid));
            end
            if (rsp_accepted !== head_result.accepted) begin
               report_mismatch("accepted", 8'(rsp_accepted), 8'(head_result.accepted));
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      int items_sent;
      int line_count;
      logic last;
      hrlc_pkg::result_type predicted;
      items_sent = 0;
      line_count = 0;
      clear_line();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         send_byte(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].last);
         predicted = predict_line_byte(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].last);
         pending_results.push_back(DIRECTED_ROWS[i].typed ? DIRECTED_ROWS[i].want
                                                          : predicted);
      end
      wait_until_drained();

      while (items_sent < RANDOM_ITEMS) begin
         build_line();
         foreach (line_bytes[i]) begin
            last = (i == line_bytes.size() - 1);
            send_byte(line_bytes[i], last);
            pending_results.push_back(predict_line_byte(line_bytes[i], last));
            items_sent++;
         end
         line_count++;
         if (line_count == 25) begin
            wait_until_drained();
         end
      end

      wait_until_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

/* http_request_line_checker_top.f */
rtl/hrlc_pkg.sv
rtl/hrlc_step.sv
rtl/http_request_line_checker_top.sv
rtl/hrlc_checker.sv
verif/tb_top.sv
